// ===== src/prtt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prtt_pkg
// Types and codes shared by the pending request tag table and its cells.
// ----------------------------------------------------------------------------
package prtt_pkg;

   localparam int SEQ_W = 32;
   localparam int OCC_W = 5;

   typedef enum logic [1:0] {
      ACT_PUSH = 2'd0,
      ACT_POP  = 2'd1,
      ACT_GEN  = 2'd2
   } action_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_SCAN = 1'b1
   } state_type;

   typedef struct packed {
      logic [1:0]       action;
      logic [SEQ_W-1:0] seq;
      logic [SEQ_W-1:0] service_handle;
      logic [SEQ_W-1:0] callback_handle;
      logic [SEQ_W-1:0] callback_arg;
   } req_type;

   typedef struct packed {
      logic             ok;
      logic [SEQ_W-1:0] new_seq;
      logic [SEQ_W-1:0] out_service;
      logic [SEQ_W-1:0] out_callback;
      logic [SEQ_W-1:0] out_arg;
      logic [OCC_W-1:0] occupancy;
   } rsp_type;

   typedef struct packed {
      logic [SEQ_W-1:0] seq;
      logic [SEQ_W-1:0] service;
      logic [SEQ_W-1:0] callback;
      logic [SEQ_W-1:0] arg;
   } entry_type;

   typedef struct packed {
      logic shift_en;
      logic load_en;
   } cell_ctl_type;

endpackage

// ===== src/prtt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prtt_cell
// One table slot: loads a new entry or takes its upper neighbor's entry.
// ----------------------------------------------------------------------------
module prtt_cell (
   input  logic                  clock,
   input  prtt_pkg::cell_ctl_type ctl,
   input  prtt_pkg::entry_type   load_data,
   input  prtt_pkg::entry_type   next_data,
   output prtt_pkg::entry_type   entry
);
   import prtt_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.load_en) begin
         entry_in = load_data;
      end else if (ctl.shift_en) begin
         entry_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== src/pending_request_tag_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pending_request_tag_table
// Outstanding request table held in a row of cells, with a sequence counter.
//
//   channel  ports                         handshake
//   ------   ----------------------------  --------------------------------
//   request  start, busy, req_data         beat taken when start && !busy
//   result   rsp_valid, rsp_data           one-cycle strobe, no back-pressure
//
// push, generate and unused codes: result in the cycle after the beat.
// pop: the row rotates once through the cell 0 compare, one entry a cycle,
// with busy high meanwhile; a pop of an empty table answers like a push.
// reset clears the counter, the fill count and the control state.
// results are never stalled.
// ----------------------------------------------------------------------------
module pending_request_tag_table #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  prtt_pkg::req_type req_data,
   output logic              rsp_valid,
   output prtt_pkg::rsp_type rsp_data
);
   import prtt_pkg::*;

   localparam int CW = $clog2(TABLE_DEPTH + 1);

   state_type        state_ff, state_in;
   logic [CW-1:0]    fill_ff, fill_in;
   logic [CW-1:0]    step_ff, step_in;
   logic [SEQ_W-1:0] key_ff, key_in;
   logic             found_ff, found_in;
   logic [SEQ_W-1:0] cnt_ff, cnt_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             accept;
   logic             hit;
   logic             shift_en;
   logic             load_en;
   logic [CW-1:0]    load_pos;
   entry_type        load_data;
   entry_type        cell_q [TABLE_DEPTH];

   assign busy   = (state_ff == ST_SCAN);
   assign accept = start && !busy;
   assign hit    = !found_ff && (cell_q[0].seq == key_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.action == ACT_POP && fill_ff != '0) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (step_ff == CW'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      fill_in      = fill_ff;
      step_in      = step_ff;
      key_in       = key_ff;
      found_in     = found_ff;
      cnt_in       = cnt_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      shift_en     = 1'b0;
      load_en      = 1'b0;
      load_pos     = fill_ff;
      load_data    = '{seq: req_data.seq, service: req_data.service_handle,
                       callback: req_data.callback_handle, arg: req_data.callback_arg};
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_in       = '0;
               rsp_valid_in = 1'b1;
               case (req_data.action)
                  ACT_PUSH: begin
                     if (fill_ff < CW'(TABLE_DEPTH)) begin
                        load_en   = 1'b1;
                        fill_in   = fill_ff + CW'(1);
                        rsp_in.ok = 1'b1;
                     end
                  end
                  ACT_POP: begin
                     if (fill_ff != '0) begin
                        rsp_valid_in = 1'b0;
                        key_in       = req_data.seq;
                        step_in      = fill_ff;
                        found_in     = 1'b0;
                     end
                  end
                  ACT_GEN: begin
                     rsp_in.ok      = 1'b1;
                     rsp_in.new_seq = cnt_ff;
                     cnt_in         = cnt_ff + SEQ_W'(1);
                  end
                  default: rsp_in.ok = 1'b0;
               endcase
               rsp_in.occupancy = OCC_W'(fill_in);
            end
         end
         ST_SCAN: begin
            shift_en  = 1'b1;
            step_in   = step_ff - CW'(1);
            load_pos  = fill_ff - CW'(1);
            load_data = cell_q[0];
            if (hit) begin
               found_in            = 1'b1;
               fill_in             = fill_ff - CW'(1);
               rsp_in.out_service  = cell_q[0].service;
               rsp_in.out_callback = cell_q[0].callback;
               rsp_in.out_arg      = cell_q[0].arg;
            end else begin
               load_en = 1'b1;
            end
            if (step_ff == CW'(1)) begin
               rsp_valid_in     = 1'b1;
               rsp_in.ok        = found_in;
               rsp_in.occupancy = OCC_W'(fill_in);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         step_ff      <= '0;
         found_ff     <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         step_ff      <= step_in;
         found_ff     <= found_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      rsp_ff <= rsp_in;
   end

   // row of cells, each taking its upper neighbor on a rotate step (the top cell keeps its own)
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      cell_ctl_type ctl;
      entry_type    next_data;

      assign ctl.shift_en = shift_en;
      assign ctl.load_en  = load_en && (load_pos == CW'(i));

      if (i == TABLE_DEPTH - 1) begin : g_last
         assign next_data = cell_q[i];
      end else begin : g_mid
         assign next_data = cell_q[i+1];
      end

      prtt_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .load_data (load_data),
         .next_data (next_data),
         .entry     (cell_q[i])
      );
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pending request tag table. A shadow of the
// table predicts the result of every accepted request beat and compares it
// field by field with the strobed result. Directed beats cover an empty pop,
// a full table, a refused push, duplicate tags, misses and the unused code.
// A long random run of generate/push/pop and unused-code traffic follows, with
// random idle gaps on the request side.
// ----------------------------------------------------------------------------
module tb;
   import prtt_pkg::*;

   localparam int          DEPTH      = 16;
   localparam logic [1:0]  ACT_UNUSED = 2'd3;
   localparam int          ITEMS      = 1500;

   class tag_table_shadow;
      entry_type   held_tags[$];
      rsp_type     due_results[$];
      logic [31:0] next_seq;
      int          mismatches;

      function new();
         next_seq   = '0;
         mismatches = 0;
      endfunction

      function void note_request(req_type r);
         rsp_type   want;
         entry_type e;
         int        hit;
         want = '0;
         hit  = -1;
         case (r.action)
            ACT_PUSH: begin
               if (held_tags.size() < DEPTH) begin
                  e.seq      = r.seq;
                  e.service  = r.service_handle;
                  e.callback = r.callback_handle;
                  e.arg      = r.callback_arg;
                  held_tags.push_back(e);
                  want.ok = 1'b1;
               end
            end
            ACT_POP: begin
               for (int i = 0; i < held_tags.size(); i++) begin
                  if (hit < 0 && held_tags[i].seq == r.seq) hit = i;
               end
               if (hit >= 0) begin
                  want.ok           = 1'b1;
                  want.out_service  = held_tags[hit].service;
                  want.out_callback = held_tags[hit].callback;
                  want.out_arg      = held_tags[hit].arg;
                  held_tags.delete(hit);
               end
            end
            ACT_GEN: begin
               want.ok      = 1'b1;
               want.new_seq = next_seq;
               next_seq     = next_seq + 32'd1;
            end
            default: ;
         endcase
         want.occupancy = OCC_W'(held_tags.size());
         due_results.push_back(want);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t: %s expected %h got %h", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (due_results.size() == 0) begin
            $display("%0t: result beat with nothing outstanding, got %h", $time, got);
            mismatches++;
            return;
         end
         want = due_results.pop_front();
         compare_field("ok", 32'(want.ok), 32'(got.ok));
         compare_field("new_seq", want.new_seq, got.new_seq);
         compare_field("out_service", want.out_service, got.out_service);
         compare_field("out_callback", want.out_callback, got.out_callback);
         compare_field("out_arg", want.out_arg, got.out_arg);
         compare_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
      endfunction
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    start     = 1'b0;
   req_type req_data  = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   tag_table_shadow shadow = new();
   bit              no_idle = 1'b0;

   pending_request_tag_table #(.TABLE_DEPTH(DEPTH)) DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) shadow.check_result(rsp_data);
   end

   function automatic int gap_len();
      int roll;
      if (no_idle) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   task automatic send(input logic [1:0] act, input logic [31:0] s,
                       input logic [31:0] h, input logic [31:0] c,
                       input logic [31:0] a);
      req_type r;
      int      gap;
      r.action          = act;
      r.seq             = s;
      r.service_handle  = h;
      r.callback_handle = c;
      r.callback_arg    = a;
      gap = gap_len();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      shadow.note_request(r);
   endtask

   task automatic push_random(input logic [31:0] s);
      send(ACT_PUSH, s, $urandom, $urandom, $urandom);
   endtask

   task automatic pop_held();
      int idx;
      idx = $urandom_range(0, shadow.held_tags.size() - 1);
      send(ACT_POP, shadow.held_tags[idx].seq, $urandom, $urandom, $urandom);
   endtask

   initial begin
      logic [31:0] s;
      int          sent;
      int          roll;
      int          push_bias;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed beats
      repeat (3) send(ACT_GEN, $urandom, $urandom, $urandom, $urandom);
      send(ACT_POP, 32'h0, 32'h0, 32'h0, 32'h0);
      for (int i = 0; i < DEPTH; i++) begin
         if (i == 0) s = 32'h0;
         else if (i == DEPTH - 1) s = 32'hFFFF_FFFF;
         else if (i == 3 || i == 7) s = 32'hA5A5_5A5A;
         else s = {8'(i), 24'($urandom)};
         if (i == 0) send(ACT_PUSH, s, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
         else if (i == 1) send(ACT_PUSH, s, 32'h0, 32'h0, 32'h0);
         else push_random(s);
      end
      send(ACT_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send(ACT_POP, 32'hA5A5_5A5A, 32'h0, 32'h0, 32'h0);
      send(ACT_POP, 32'h1234_5678, 32'h0, 32'h0, 32'h0);
      send(ACT_POP, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
      send(ACT_POP, 32'h0, 32'h0, 32'h0, 32'h0);
      send(ACT_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send(ACT_POP, 32'hA5A5_5A5A, 32'h0, 32'h0, 32'h0);

      // random traffic in phases that lean toward filling or draining
      sent      = 0;
      push_bias = 50;
      while (sent < ITEMS) begin
         if (sent % 50 == 0) begin
            push_bias = ($urandom_range(0, 1) == 1) ? 70 : 30;
            no_idle   = ($urandom_range(0, 3) == 0);
         end
         roll = $urandom_range(0, 99);
         if (roll < 5) begin
            send(ACT_UNUSED, $urandom, $urandom, $urandom, $urandom);
         end else if (roll < 12) begin
            send(ACT_POP, $urandom, $urandom, $urandom, $urandom);
            sent++;
         end else if (roll < 18) begin
            // push a tag that is already held, if the table holds any
            if (shadow.held_tags.size() > 0)
               push_random(shadow.held_tags[$urandom_range(0,
                           shadow.held_tags.size() - 1)].seq);
            else
               push_random($urandom);
            sent++;
         end else if ($urandom_range(0, 99) < push_bias ||
                      shadow.held_tags.size() == 0) begin
            // generate then push the issued tag
            s = shadow.next_seq;
            send(ACT_GEN, $urandom, $urandom, $urandom, $urandom);
            push_random(s);
            sent += 2;
         end else begin
            pop_held();
            sent++;
         end
      end
      start <= 1'b0;

      while (shadow.due_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (shadow.mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

// ===== sim.f =====
src/prtt_pkg.sv
src/prtt_cell.sv
src/pending_request_tag_table.sv
tb/sv/tb.sv
